// File: rtl/quaternion_attitude_integrator_assert.svh
// Assertion macros for the attitude integrator.
// Used by the top level; expects clk and rst in scope.
`ifndef QUATERNION_ATTITUDE_INTEGRATOR_ASSERT_SVH
`define QUATERNION_ATTITUDE_INTEGRATOR_ASSERT_SVH

// Same-cycle implication.
`define QAI_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("qai assertion failed");

// Next-cycle implication.
`define QAI_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("qai assertion failed");

`endif

// File: rtl/qai_pkg.sv
// Shared types and constants for the attitude integrator.
// No dependencies.
package qai_pkg;

  localparam int OMEGA_W    = 24;
  localparam int STEP_W     = 16;
  localparam int STEP_SHIFT = 29;
  localparam int LOP_W      = 46;   // lo * dt plus rounding
  localparam int MUL_W      = 32;
  localparam int NMAG_W     = 30;   // normalized magnitude width
  localparam int NORM_LO    = 29;
  localparam int NORM_HI    = 30;
  localparam int SUMSQ_W    = 62;
  localparam int ROOT_W     = 31;

  localparam logic [3:0] N_PROD  = 4'd12;
  localparam logic [3:0] N_SCALE = 4'd8;
  localparam logic [3:0] N_SQ    = 4'd4;

  localparam logic [1:0] IX = 2'd0;
  localparam logic [1:0] IY = 2'd1;
  localparam logic [1:0] IZ = 2'd2;
  localparam logic [1:0] IW = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE, S_PROD, S_SCALE, S_SUM, S_SHIFT, S_SQ,
    S_ROOT_GO, S_ROOT_WAIT, S_DIV_GO, S_DIV_WAIT, S_OUT
  } qai_state_t;

  typedef struct packed {
    logic [1:0] comp;
    logic [1:0] w_sel;
    logic [1:0] q_sel;
    logic       neg;
  } qai_term_t;

  // Hamilton product (w,0) * q, one term per entry.
  function automatic qai_term_t term_sel(input logic [3:0] j);
    qai_term_t t;
    case (j)
      4'd0:  t = '{IX, IX, IW, 1'b0};
      4'd1:  t = '{IX, IY, IZ, 1'b0};
      4'd2:  t = '{IX, IZ, IY, 1'b1};
      4'd3:  t = '{IY, IY, IW, 1'b0};
      4'd4:  t = '{IY, IZ, IX, 1'b0};
      4'd5:  t = '{IY, IX, IZ, 1'b1};
      4'd6:  t = '{IZ, IZ, IW, 1'b0};
      4'd7:  t = '{IZ, IX, IY, 1'b0};
      4'd8:  t = '{IZ, IY, IX, 1'b1};
      4'd9:  t = '{IW, IX, IX, 1'b1};
      4'd10: t = '{IW, IY, IY, 1'b1};
      4'd11: t = '{IW, IZ, IZ, 1'b1};
      default: t = '0;
    endcase
    return t;
  endfunction

endpackage

// File: rtl/qai_sample_if.sv
// Input channel: angular velocity and time step.
// Depends on qai_pkg.
interface qai_sample_if import qai_pkg::*;;
  logic                      valid;
  logic                      ready;
  logic signed [OMEGA_W-1:0] omega_x;
  logic signed [OMEGA_W-1:0] omega_y;
  logic signed [OMEGA_W-1:0] omega_z;
  logic [STEP_W-1:0]         step_time;

  modport source(output valid, omega_x, omega_y, omega_z, step_time, input ready);
  modport sink(input valid, omega_x, omega_y, omega_z, step_time, output ready);
endinterface

// File: rtl/qai_result_if.sv
// Output channel: normalized attitude quaternion.
// No dependencies.
interface qai_result_if #(parameter int QUAT_WIDTH = 16);
  logic                         valid;
  logic                         ready;
  logic signed [QUAT_WIDTH-1:0] quat_x;
  logic signed [QUAT_WIDTH-1:0] quat_y;
  logic signed [QUAT_WIDTH-1:0] quat_z;
  logic signed [QUAT_WIDTH-1:0] quat_w;

  modport source(output valid, quat_x, quat_y, quat_z, quat_w, input ready);
  modport sink(input valid, quat_x, quat_y, quat_z, quat_w, output ready);
endinterface

// File: rtl/qai_mul.sv
// Shared signed multiplier with registered product.
// Depends on qai_pkg.
module qai_mul import qai_pkg::*; (
  input  logic                        clk,
  input  logic signed [MUL_W-1:0]     a,
  input  logic signed [MUL_W-1:0]     b,
  output logic signed [2*MUL_W-1:0]   p
);
  always_ff @(posedge clk) begin
    p <= a * b;
  end
endmodule

// File: rtl/qai_isqrt.sv
// Iterative integer square root, one result bit per cycle.
// Depends on qai_pkg.
module qai_isqrt import qai_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [SUMSQ_W-1:0] n,
  output logic               done,
  output logic [ROOT_W-1:0]  root
);
  localparam int AW = 64;

  logic [AW-1:0] rem;
  logic [AW-1:0] res;
  logic [AW-1:0] bitv;
  logic [AW-1:0] trial;
  logic [4:0]    cnt;
  logic          busy;

  assign trial = res + bitv;
  assign root  = res[ROOT_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem  <= AW'(n);
        res  <= '0;
        bitv <= AW'(1) << SUMSQ_W;
        cnt  <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        if (rem >= trial) begin
          rem <= rem - trial;
          res <= (res >> 1) + bitv;
        end else begin
          res <= res >> 1;
        end
        bitv <= bitv >> 2;
        cnt  <= cnt + 5'd1;
        if (cnt == 5'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

// File: rtl/qai_div.sv
// Restoring divider: round(m * 2^QF / len), one quotient bit per cycle.
// Depends on qai_pkg. Requires m <= len.
module qai_div import qai_pkg::*; #(
  parameter int QF = 14
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [NMAG_W-1:0] m,
  input  logic [ROOT_W-1:0] len,
  output logic              done,
  output logic [QF:0]       quo
);
  localparam int NW = NMAG_W + QF + 1;
  localparam int CW = $clog2(QF + 2);

  logic [NW-1:0]     num;
  logic [ROOT_W-1:0] rem;
  logic [QF:0]       low;
  logic [ROOT_W:0]   r2;
  logic [CW-1:0]     cnt;
  logic              busy;

  assign num = (NW'(m) << QF) + NW'(len >> 1);
  assign r2  = {rem, low[QF]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        // quotient fits QF+1 bits, so the top part is already below len
        rem  <= ROOT_W'(num[NW-1:QF+1]);
        low  <= num[QF:0];
        cnt  <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        if (r2 >= {1'b0, len}) begin
          rem <= ROOT_W'(r2 - {1'b0, len});
          quo <= {quo[QF-1:0], 1'b1};
        end else begin
          rem <= r2[ROOT_W-1:0];
          quo <= {quo[QF-1:0], 1'b0};
        end
        low <= low << 1;
        cnt <= cnt + CW'(1);
        if (cnt == CW'(QF)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

// File: rtl/quaternion_attitude_integrator.sv
// Quaternion attitude integrator, first order, with renormalization.
// Channels: sample (omega_x/y/z Q12.12, step_time Q0.16) in, result
// (quat_x/y/z/w, signed, QUAT_WIDTH-2 fraction bits) out, valid/ready each.
// One result per sample. The block takes a sample only while idle and then
// runs a sequencer over one shared 32x32 multiplier, an iterative square
// root and an iterative divider:
//   products, step scale, sum, shift, squares, square root, one divide
//   per component and the output stage,
// where the shift moves the magnitudes until the largest one lands in
// [2^29, 2^30); an all-zero sum skips the square root and divides.
// The next sample is taken only after the sequencer is back in idle,
// as the multiplier and divider are time shared.
// Reset (rst, synchronous) sets the attitude to identity and empties the
// output register. A finished result waits in the output register while
// the receiver stalls; a new sample may be taken meanwhile, but its result
// is held back until the previous one is taken.
// Depends on qai_pkg, qai_sample_if, qai_result_if, qai_mul, qai_isqrt, qai_div.
module quaternion_attitude_integrator import qai_pkg::*; #(
  parameter int QUAT_WIDTH = 16
) (
  input  logic          clk,
  input  logic          rst,
  qai_sample_if.sink    sample,
  qai_result_if.source  result
);
  localparam int F   = QUAT_WIDTH - 2;
  localparam int PW  = QUAT_WIDTH + 26;
  localparam int DMW = QUAT_WIDTH + 12;
  localparam int SW  = QUAT_WIDTH + 13;
  localparam int MW  = (SW > 31) ? SW : 31;

  qai_state_t state, state_next;

  logic signed [OMEGA_W-1:0]    wv [3];
  logic [STEP_W-1:0]            dt;
  logic signed [QUAT_WIDTH-1:0] q [4];
  logic signed [QUAT_WIDTH-1:0] oq [4];
  logic signed [PW-1:0]         acc [4];
  logic [DMW-1:0]               dm [4];
  logic [MW-1:0]                sm [4];
  logic                         sneg [4];
  logic [SUMSQ_W-1:0]           sumsq;
  logic [3:0]                   cnt;
  logic [1:0]                   di;
  logic                         out_valid;

  logic       tag_valid, tag_neg, tag_lo;
  logic [1:0] tag_comp;
  logic       issue, ineg, ilo;
  logic [1:0] icomp;

  logic signed [MUL_W-1:0]   ma, mb;
  logic signed [2*MUL_W-1:0] prod;
  qai_term_t                 term;
  logic signed [PW-1:0]      asel;
  logic [PW-1:0]             pm;

  logic signed [SW-1:0] dsg [4];
  logic signed [SW-1:0] ssum [4];
  logic [MW-1:0]        smag [4];
  logic                 over, under, allzero;
  logic [LOP_W-1:0]     lo_round;

  logic              root_start, root_done;
  logic [ROOT_W-1:0] root_len;
  logic              div_start, div_done;
  logic [F:0]        quo;
  logic              accept, out_load;

  assign accept   = sample.valid && sample.ready;
  assign out_load = (state == S_OUT) && (!out_valid || result.ready);

  qai_mul u_mul (.clk(clk), .a(ma), .b(mb), .p(prod));

  qai_isqrt u_isqrt (
    .clk(clk), .rst(rst), .start(root_start), .n(sumsq),
    .done(root_done), .root(root_len)
  );

  qai_div #(.QF(F)) u_div (
    .clk(clk), .rst(rst), .start(div_start), .m(sm[di][NMAG_W-1:0]),
    .len(root_len), .done(div_done), .quo(quo)
  );

  // sum, magnitude and range checks
  always_comb begin
    over    = 1'b0;
    under   = 1'b1;
    allzero = 1'b1;
    for (int i = 0; i < 4; i++) begin
      dsg[i]  = acc[i][PW-1] ? -$signed(SW'(dm[i])) : $signed(SW'(dm[i]));
      ssum[i] = SW'(q[i]) + dsg[i];
      smag[i] = ssum[i][SW-1] ? MW'(-ssum[i]) : MW'(ssum[i]);
      if (sm[i][MW-1:NORM_HI] != '0) over = 1'b1;
      if (sm[i][MW-1:NORM_LO] != '0) under = 1'b0;
      if (sm[i] != '0) allzero = 1'b0;
    end
  end

  assign lo_round = (prod[LOP_W-1:0] + (LOP_W'(1) << (STEP_SHIFT - 1))) >> STEP_SHIFT;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:      if (accept) state_next = S_PROD;
      S_PROD:      if (cnt == N_PROD) state_next = S_SCALE;
      S_SCALE:     if (cnt == N_SCALE) state_next = S_SUM;
      S_SUM:       state_next = S_SHIFT;
      S_SHIFT: begin
        if (allzero) state_next = S_OUT;
        else if (!over && !under) state_next = S_SQ;
      end
      S_SQ:        if (cnt == N_SQ) state_next = S_ROOT_GO;
      S_ROOT_GO:   state_next = S_ROOT_WAIT;
      S_ROOT_WAIT: if (root_done) state_next = S_DIV_GO;
      S_DIV_GO:    state_next = S_DIV_WAIT;
      S_DIV_WAIT:  if (div_done) state_next = (di == IW) ? S_OUT : S_DIV_GO;
      S_OUT:       if (out_load) state_next = S_IDLE;
      default:     state_next = S_IDLE;
    endcase
  end

  always_comb begin
    sample.ready = (state == S_IDLE);
    root_start   = (state == S_ROOT_GO);
    div_start    = (state == S_DIV_GO);
    issue = 1'b0;
    icomp = '0;
    ineg  = 1'b0;
    ilo   = 1'b0;
    ma    = '0;
    mb    = '0;
    term  = term_sel(cnt);
    asel  = acc[cnt[2:1]];
    pm    = asel[PW-1] ? PW'(-asel) : PW'(asel);
    case (state)
      S_PROD: begin
        if (cnt < N_PROD) begin
          issue = 1'b1;
          icomp = term.comp;
          ineg  = term.neg;
          ma    = MUL_W'(wv[term.w_sel]);
          mb    = MUL_W'(q[term.q_sel]);
        end
      end
      S_SCALE: begin
        if (cnt < N_SCALE) begin
          issue = 1'b1;
          icomp = cnt[2:1];
          ilo   = cnt[0];
          ma    = cnt[0] ? signed'(MUL_W'(pm[STEP_SHIFT-1:0]))
                         : signed'(MUL_W'(pm[PW-1:STEP_SHIFT]));
          mb    = signed'(MUL_W'(dt));
        end
      end
      S_SQ: begin
        if (cnt < N_SQ) begin
          issue = 1'b1;
          ma    = signed'(MUL_W'(sm[cnt[1:0]][NMAG_W-1:0]));
          mb    = signed'(MUL_W'(sm[cnt[1:0]][NMAG_W-1:0]));
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      tag_valid <= 1'b0;
      out_valid <= 1'b0;
      q[0] <= '0;
      q[1] <= '0;
      q[2] <= '0;
      q[3] <= QUAT_WIDTH'(1) << F;
    end else begin
      state     <= state_next;
      cnt       <= (state_next != state) ? '0 : cnt + 4'd1;
      tag_valid <= issue;
      tag_comp  <= icomp;
      tag_neg   <= ineg;
      tag_lo    <= ilo;

      if (out_load) begin
        out_valid <= 1'b1;
        for (int i = 0; i < 4; i++) oq[i] <= q[i];
      end else if (out_valid && result.ready) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (accept) begin
            wv[0] <= sample.omega_x;
            wv[1] <= sample.omega_y;
            wv[2] <= sample.omega_z;
            dt    <= sample.step_time;
            sumsq <= '0;
            di    <= '0;
            for (int i = 0; i < 4; i++) begin
              acc[i] <= '0;
              dm[i]  <= '0;
            end
          end
        end
        S_PROD: begin
          if (tag_valid)
            acc[tag_comp] <= acc[tag_comp] + (tag_neg ? -PW'(prod) : PW'(prod));
        end
        S_SCALE: begin
          if (tag_valid)
            dm[tag_comp] <= dm[tag_comp] + (tag_lo ? DMW'(lo_round) : DMW'(prod));
        end
        S_SUM: begin
          for (int i = 0; i < 4; i++) begin
            sm[i]   <= smag[i];
            sneg[i] <= ssum[i][SW-1];
          end
        end
        S_SHIFT: begin
          if (allzero) begin
            for (int i = 0; i < 4; i++) q[i] <= '0;
          end else if (over) begin
            for (int i = 0; i < 4; i++) sm[i] <= sm[i] >> 1;
          end else if (under) begin
            for (int i = 0; i < 4; i++) sm[i] <= sm[i] << 1;
          end
        end
        S_SQ: begin
          if (tag_valid) sumsq <= sumsq + SUMSQ_W'(prod[2*NMAG_W-1:0]);
        end
        S_DIV_WAIT: begin
          if (div_done) begin
            q[di] <= sneg[di] ? -QUAT_WIDTH'(quo) : QUAT_WIDTH'(quo);
            di    <= di + 2'd1;
          end
        end
        default: ;
      endcase
    end
  end

  assign result.valid  = out_valid;
  assign result.quat_x = oq[0];
  assign result.quat_y = oq[1];
  assign result.quat_z = oq[2];
  assign result.quat_w = oq[3];

`include "quaternion_attitude_integrator_assert.svh"

  `QAI_ASSERT_NEXT(a_busy_after_accept, sample.valid && sample.ready, state == S_PROD)
  `QAI_ASSERT_SAME(a_root_done_wait, root_done, state == S_ROOT_WAIT)
  `QAI_ASSERT_SAME(a_div_done_wait, div_done, state == S_DIV_WAIT)
  `QAI_ASSERT_SAME(a_norm_range, state == S_SQ, !over && !under)

endmodule

// File: bench/tb.sv
// Self-checking bench for quaternion_attitude_integrator.
// Depends on qai_pkg, qai_sample_if, qai_result_if and the RTL top level.
`timescale 1ns / 100ps

module tb;
  import qai_pkg::*;

  localparam int QW = 16;
  localparam int QF = QW - 2;

  typedef struct {
    logic signed [OMEGA_W-1:0] wx;
    logic signed [OMEGA_W-1:0] wy;
    logic signed [OMEGA_W-1:0] wz;
    logic [STEP_W-1:0]         dt;
  } rate_t;

  typedef struct {
    logic signed [QW-1:0] x;
    logic signed [QW-1:0] y;
    logic signed [QW-1:0] z;
    logic signed [QW-1:0] w;
  } quat_t;

  logic clk;
  logic rst;

  qai_sample_if sif ();
  qai_result_if #(.QUAT_WIDTH(QW)) rif ();

  quaternion_attitude_integrator #(.QUAT_WIDTH(QW)) dut (
    .clk(clk),
    .rst(rst),
    .sample(sif.sink),
    .result(rif.source)
  );

  rate_t pending_rates[$];
  quat_t attitude_due[$];
  longint att[4];   // x, y, z, w
  int    mismatches;
  int    taken_count;
  logic  in_taken;
  int    hold_cycles;
  logic  hold_done;
  logic  calm;

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  function automatic longint unsigned root_floor(input longint unsigned n);
    longint unsigned res;
    longint unsigned b;
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n = n - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // round(p * dt / 2^29), half away from zero
  function automatic longint step_scale(input longint p, input longint unsigned dt);
    longint unsigned m;
    longint unsigned r;
    m = (p < 0) ? -p : p;
    r = (m >> STEP_SHIFT) * dt
        + (((m & ((64'd1 << STEP_SHIFT) - 1)) * dt + (64'd1 << (STEP_SHIFT - 1)))
           >> STEP_SHIFT);
    return (p < 0) ? -longint'(r) : longint'(r);
  endfunction

  function automatic quat_t integrate(input rate_t it);
    longint wx, wy, wz;
    longint p[4];
    longint s[4];
    longint unsigned m[4];
    longint unsigned maxm, sum, len, r;
    longint v;
    quat_t q;
    wx = it.wx;
    wy = it.wy;
    wz = it.wz;
    p[0] = wx * att[3] + wy * att[2] - wz * att[1];
    p[1] = wy * att[3] + wz * att[0] - wx * att[2];
    p[2] = wz * att[3] + wx * att[1] - wy * att[0];
    p[3] = -wx * att[0] - wy * att[1] - wz * att[2];
    maxm = 0;
    for (int i = 0; i < 4; i++) begin
      s[i] = att[i] + step_scale(p[i], it.dt);
      m[i] = (s[i] < 0) ? -s[i] : s[i];
      if (m[i] > maxm) maxm = m[i];
    end
    if (maxm != 0) begin
      while (maxm >= (64'd1 << NORM_HI)) begin
        maxm = maxm >> 1;
        for (int i = 0; i < 4; i++) m[i] = m[i] >> 1;
      end
      while (maxm < (64'd1 << NORM_LO)) begin
        maxm = maxm << 1;
        for (int i = 0; i < 4; i++) m[i] = m[i] << 1;
      end
      sum = 0;
      for (int i = 0; i < 4; i++) sum += m[i] * m[i];
      len = root_floor(sum);
      for (int i = 0; i < 4; i++) begin
        r = ((m[i] << QF) + (len >> 1)) / len;
        v = (s[i] < 0) ? -longint'(r) : longint'(r);
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        att[i] = v;
      end
    end else begin
      for (int i = 0; i < 4; i++) att[i] = 0;
    end
    q.x = QW'(att[0]);
    q.y = QW'(att[1]);
    q.z = QW'(att[2]);
    q.w = QW'(att[3]);
    return q;
  endfunction

  // mostly moderate rates, sometimes the full field range
  function automatic logic signed [OMEGA_W-1:0] pick_rate();
    int sel;
    sel = $urandom_range(9);
    if (sel < 2) return OMEGA_W'($urandom);
    if (sel < 3) return OMEGA_W'(int'($urandom_range(255)) - 128);
    return OMEGA_W'(int'($urandom_range(131071)) - 65536);
  endfunction

  function automatic rate_t make_rate(input int wx, input int wy, input int wz,
                                      input int dt);
    rate_t it;
    it.wx = OMEGA_W'(wx);
    it.wy = OMEGA_W'(wy);
    it.wz = OMEGA_W'(wz);
    it.dt = STEP_W'(dt);
    return it;
  endfunction

  // input side: accept, predict
  always @(posedge clk) begin
    if (rst) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= sif.valid && sif.ready;
      if (sif.valid && sif.ready) begin
        attitude_due.push_back(integrate(make_rate(sif.omega_x, sif.omega_y,
                                                   sif.omega_z, sif.step_time)));
        taken_count <= taken_count + 1;
      end
    end
  end

  // output side: compare
  always @(posedge clk) begin
    quat_t want;
    if (!rst && rif.valid && rif.ready) begin
      if (attitude_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result x=%0d y=%0d z=%0d w=%0d",
                   rif.quat_x, rif.quat_y, rif.quat_z, rif.quat_w);
      end else begin
        want = attitude_due.pop_front();
        if (want.x !== rif.quat_x || want.y !== rif.quat_y ||
            want.z !== rif.quat_z || want.w !== rif.quat_w) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp %0d %0d %0d %0d got %0d %0d %0d %0d",
                     want.x, want.y, want.z, want.w,
                     rif.quat_x, rif.quat_y, rif.quat_z, rif.quat_w);
        end
      end
    end
  end

  // long receiver hold-off, once
  always @(posedge clk) begin
    if (rst) begin
      hold_cycles <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && taken_count == 40) begin
      hold_cycles <= 800;
      hold_done <= 1'b1;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
    end
  end

  assign calm = (taken_count >= 500) && (taken_count < 700);

  // driver
  always @(negedge clk) begin
    rate_t it;
    if (!rst && (!sif.valid || in_taken)) begin
      if (pending_rates.size() > 0 && (calm || $urandom_range(99) >= 27)) begin
        it = pending_rates.pop_front();
        sif.omega_x <= it.wx;
        sif.omega_y <= it.wy;
        sif.omega_z <= it.wz;
        sif.step_time <= it.dt;
        sif.valid <= 1'b1;
      end else begin
        sif.valid <= 1'b0;
      end
    end
  end

  // receiver
  always @(negedge clk) begin
    if (!rst)
      rif.ready <= (hold_cycles == 0) && (calm || $urandom_range(99) >= 27);
  end

  initial begin
    int mx;
    int mn;
    mx = 8388607;
    mn = -8388608;
    mismatches = 0;
    taken_count = 0;
    foreach (att[i]) att[i] = 0;
    att[3] = 64'd1 << QF;
    rst = 1'b1;
    sif.valid = 1'b0;
    sif.omega_x = '0;
    sif.omega_y = '0;
    sif.omega_z = '0;
    sif.step_time = '0;
    rif.ready = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: zero step renormalizes, extremes of each field
    pending_rates.push_back(make_rate(0, 0, 0, 0));
    pending_rates.push_back(make_rate(0, 0, 0, 65535));
    pending_rates.push_back(make_rate(4096, 0, 0, 6554));
    pending_rates.push_back(make_rate(0, 4096, 0, 6554));
    pending_rates.push_back(make_rate(0, 0, 4096, 6554));
    pending_rates.push_back(make_rate(mx, 0, 0, 65535));
    pending_rates.push_back(make_rate(0, mn, 0, 65535));
    pending_rates.push_back(make_rate(0, 0, mx, 1));
    pending_rates.push_back(make_rate(mx, mx, mx, 65535));
    pending_rates.push_back(make_rate(mn, mn, mn, 65535));
    pending_rates.push_back(make_rate(mx, mn, mx, 32768));
    pending_rates.push_back(make_rate(-1, -1, -1, 65535));
    pending_rates.push_back(make_rate(1, 1, 1, 1));
    pending_rates.push_back(make_rate(mn, mx, 0, 0));
    pending_rates.push_back(make_rate(-4096, 8192, -12288, 20000));
    pending_rates.push_back(make_rate(12868, 0, 0, 32768));
    pending_rates.push_back(make_rate(0, 0, 0, 0));
    pending_rates.push_back(make_rate(65536, -65536, 0, 1000));

    // sender pauses until everything has come back
    wait (pending_rates.size() == 0 && !sif.valid && attitude_due.size() == 0);
    @(negedge clk);

    for (int n = 0; n < 1430; n++) begin
      rate_t it;
      it.wx = pick_rate();
      it.wy = pick_rate();
      it.wz = pick_rate();
      case ($urandom_range(7))
        0: it.dt = '0;
        1: it.dt = STEP_W'($urandom_range(15));
        2: it.dt = STEP_W'(65535 - $urandom_range(15));
        default: it.dt = STEP_W'($urandom);
      endcase
      pending_rates.push_back(it);
    end

    wait (pending_rates.size() == 0 && !sif.valid && attitude_due.size() == 0);
    repeat (300) @(posedge clk);
    if (mismatches == 0 && attitude_due.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("simulation failed");
    $finish;
  end

endmodule
